FILE: sv/ftvn_pkg.sv
// ----------------------------------------------------------------------------
// ftvn_pkg
// Shared types and constants for the fan triangulation vertex normal core.
// ----------------------------------------------------------------------------
`default_nettype none

package ftvn_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int ACC_BITS_DEF     = 48;

  localparam int KIND_W     = 2;
  localparam int VIDX_W     = 10;
  localparam int CORNER_W   = 11;
  localparam int POS_W      = 16;
  localparam int NORM_W     = 16;
  localparam int DIFF_W     = 17;
  localparam int PROD_W     = 34;
  localparam int FACE_W     = 36;
  localparam int MAG_W      = 30;
  localparam int SQ_W       = 64;
  localparam int LEN_W      = 31;
  localparam int QUO_W      = 15;
  localparam int REM_W      = 46;
  localparam int FRAC_BITS  = 14;
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_CORNER,
    KIND_READ,
    KIND_NOP
  } kind_t;

  typedef enum logic [1:0] {
    CC_NONE,
    CC_ONE,
    CC_TWO,
    CC_MANY
  } ccount_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_FACE,
    OP_ADD,
    OP_READ,
    OP_ERR,
    OP_BADREAD
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                   op;
    logic [CORNER_W-1:0]       a;
    logic [CORNER_W-1:0]       b;
    logic [CORNER_W-1:0]       c;
    logic signed [POS_W-1:0]   px;
    logic signed [POS_W-1:0]   py;
    logic signed [POS_W-1:0]   pz;
  } cmd_t;

  typedef struct packed {
    logic                      tri_valid;
    logic [VIDX_W-1:0]         tri_first;
    logic [VIDX_W-1:0]         tri_prev;
    logic [VIDX_W-1:0]         tri_cur;
    logic                      norm_valid;
    logic signed [NORM_W-1:0]  norm_x;
    logic signed [NORM_W-1:0]  norm_y;
    logic signed [NORM_W-1:0]  norm_z;
    logic                      zero_normal;
    logic                      index_error;
  } res_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_VRD,
    ST_VCAP,
    ST_DIFF,
    ST_MUL,
    ST_MACC,
    ST_ARD,
    ST_AWR,
    ST_NRD,
    ST_NCAP,
    ST_NSH,
    ST_NSQ,
    ST_NSUM,
    ST_SQRT,
    ST_DINIT,
    ST_DIV,
    ST_EMIT
  } back_st_t;

endpackage

`default_nettype wire

FILE: sv/fan_triangulate_vertex_normals_core.sv
// ----------------------------------------------------------------------------
// fan_triangulate_vertex_normals_core
// Smooth vertex normal accumulation over fan-triangulated polygons.
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    kind, index, corner, start, position
//   out      out  out_valid / out_ready  triangle or unit normal, flags
//   cfg      in   cfg_valid / cfg_ready  vertices_in_use
//
// After reset the accumulator RAM is cleared, all MAX_VERTICES entries, with
// in_ready low; cfg beats are taken at all times.
// The front takes one in beat per cycle while the command queue has room.
// Back end, one command at a time: load writes a vertex and clears its
// accumulator; a later fan corner does one accumulator read-modify-write; the
// third corner does three vertex reads, one shared multiplier over six
// products and three accumulator read-modify-writes; a read does the shift,
// 32-step root and three 15-step divides. A held out beat stalls the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fan_triangulate_vertex_normals_core #(
  parameter int MAX_VERTICES = ftvn_pkg::MAX_VERTICES_DEF,
  parameter int ACC_BITS     = ftvn_pkg::ACC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ftvn_pkg::KIND_W-1:0]        in_kind,
  input  logic [ftvn_pkg::VIDX_W-1:0]        in_vertex_index,
  input  logic [ftvn_pkg::CORNER_W-1:0]      in_corner_number,
  input  logic                               in_poly_start,
  input  logic signed [ftvn_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [ftvn_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [ftvn_pkg::POS_W-1:0]  in_pos_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_tri_valid,
  output logic [ftvn_pkg::VIDX_W-1:0]        out_tri_first,
  output logic [ftvn_pkg::VIDX_W-1:0]        out_tri_prev,
  output logic [ftvn_pkg::VIDX_W-1:0]        out_tri_cur,
  output logic                               out_norm_valid,
  output logic signed [ftvn_pkg::NORM_W-1:0] out_norm_x,
  output logic signed [ftvn_pkg::NORM_W-1:0] out_norm_y,
  output logic signed [ftvn_pkg::NORM_W-1:0] out_norm_z,
  output logic                               out_zero_normal,
  output logic                               out_index_error,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ftvn_pkg::CORNER_W-1:0]      cfg_vertices_in_use
);

  import ftvn_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push_valid, push_ready, pop_valid, pop_ready;
  logic clearing;
  res_t res;

  ftvn_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_vertex_index     (in_vertex_index),
    .in_corner_number    (in_corner_number),
    .in_poly_start       (in_poly_start),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_pos_z            (in_pos_z),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_vertices_in_use (cfg_vertices_in_use),
    .run_en              (!clearing),
    .q_valid             (push_valid),
    .q_ready             (push_ready),
    .q_cmd               (push_cmd)
  );

  ftvn_cmd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_cmd)
  );

  ftvn_back #(.MAX_VERTICES(MAX_VERTICES), .ACC_BITS(ACC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_tri_valid   = res.tri_valid;
  assign out_tri_first   = res.tri_first;
  assign out_tri_prev    = res.tri_prev;
  assign out_tri_cur     = res.tri_cur;
  assign out_norm_valid  = res.norm_valid;
  assign out_norm_x      = res.norm_x;
  assign out_norm_y      = res.norm_y;
  assign out_norm_z      = res.norm_z;
  assign out_zero_normal = res.zero_normal;
  assign out_index_error = res.index_error;

endmodule

`default_nettype wire

FILE: sv/ftvn_ram.sv
// ----------------------------------------------------------------------------
// ftvn_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ftvn_ram #(
  parameter int WIDTH = 3 * ftvn_pkg::POS_W,
  parameter int DEPTH = ftvn_pkg::MAX_VERTICES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/ftvn_front.sv
// ----------------------------------------------------------------------------
// ftvn_front
// Accepts input beats, checks indices, tracks polygon corners and issues
// commands to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ftvn_front #(
  parameter int MAX_VERTICES = ftvn_pkg::MAX_VERTICES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ftvn_pkg::KIND_W-1:0]          in_kind,
  input  logic [ftvn_pkg::VIDX_W-1:0]          in_vertex_index,
  input  logic [ftvn_pkg::CORNER_W-1:0]        in_corner_number,
  input  logic                                 in_poly_start,
  input  logic signed [ftvn_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [ftvn_pkg::POS_W-1:0]    in_pos_y,
  input  logic signed [ftvn_pkg::POS_W-1:0]    in_pos_z,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ftvn_pkg::CORNER_W-1:0]        cfg_vertices_in_use,
  input  logic                                 run_en,
  output logic                                 q_valid,
  input  logic                                 q_ready,
  output ftvn_pkg::cmd_t                       q_cmd
);

  import ftvn_pkg::*;

  localparam logic [16:0] MAXV = 17'(MAX_VERTICES);

  logic [CORNER_W-1:0] viu_r;
  ccount_t             cnt_r, cnt_nxt;
  logic [CORNER_W-1:0] first_r, first_nxt;
  logic [CORNER_W-1:0] prev_r, prev_nxt;
  logic                accept;
  logic                corner_bad;
  logic                read_bad;
  logic [CORNER_W-1:0] cur;

  assign in_ready  = run_en && q_ready;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_comb begin
    cur        = in_corner_number - CORNER_W'(1);
    corner_bad = (in_corner_number == '0) || (in_corner_number > viu_r) ||
                 (17'(in_corner_number) > MAXV);
    read_bad   = (CORNER_W'(in_vertex_index) >= viu_r) ||
                 (17'(in_vertex_index) >= MAXV);
    cnt_nxt    = cnt_r;
    first_nxt  = first_r;
    prev_nxt   = prev_r;
    q_valid    = 1'b0;
    q_cmd.op   = OP_LOAD;
    q_cmd.a    = CORNER_W'(in_vertex_index);
    q_cmd.b    = prev_r;
    q_cmd.c    = cur;
    q_cmd.px   = in_pos_x;
    q_cmd.py   = in_pos_y;
    q_cmd.pz   = in_pos_z;
    if (accept) begin
      unique case (kind_t'(in_kind))
        KIND_LOAD: begin
          q_valid = (17'(in_vertex_index) < MAXV);
        end
        KIND_CORNER: begin
          priority if (corner_bad) begin
            q_valid  = 1'b1;
            q_cmd.op = OP_ERR;
          end else if (in_poly_start || cnt_r == CC_NONE) begin
            first_nxt = cur;
            prev_nxt  = cur;
            cnt_nxt   = CC_ONE;
          end else if (cnt_r == CC_ONE) begin
            prev_nxt = cur;
            cnt_nxt  = CC_TWO;
          end else begin
            q_valid  = 1'b1;
            q_cmd.op = (cnt_r == CC_TWO) ? OP_FACE : OP_ADD;
            q_cmd.a  = first_r;
            prev_nxt = cur;
            cnt_nxt  = CC_MANY;
          end
        end
        KIND_READ: begin
          q_valid  = 1'b1;
          q_cmd.op = read_bad ? OP_BADREAD : OP_READ;
        end
        KIND_NOP: begin
          q_valid = 1'b0;
        end
        default: begin
          q_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      viu_r   <= '0;
      cnt_r   <= CC_NONE;
      first_r <= '0;
      prev_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        viu_r <= cfg_vertices_in_use;
      end
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ftvn_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ftvn_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ftvn_cmd_fifo #(
  parameter int DEPTH = ftvn_pkg::FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  ftvn_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output ftvn_pkg::cmd_t pop_data
);

  import ftvn_pkg::*;

  localparam int PW = $clog2(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [PW:0]   cnt_r;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != (PW+1)'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PW'(DEPTH-1)) ? '0 : wr_r + PW'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == PW'(DEPTH-1)) ? '0 : rd_r + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + (PW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (PW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/ftvn_back.sv
// ----------------------------------------------------------------------------
// ftvn_back
// Executes commands: vertex loads, face normal and accumulator updates, and
// normal reads with shift, square root and division; holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ftvn_back #(
  parameter int MAX_VERTICES = ftvn_pkg::MAX_VERTICES_DEF,
  parameter int ACC_BITS     = ftvn_pkg::ACC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  ftvn_pkg::cmd_t cmd,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_ready,
  output ftvn_pkg::res_t out_res
);

  import ftvn_pkg::*;

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int VW    = 3 * POS_W;
  localparam int AccW  = 3 * ACC_BITS;
  localparam int AccP1 = ACC_BITS + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);

  back_st_t st_r, st_nxt;
  cmd_t     cmd_r;

  logic [AW-1:0]             clr_r;
  logic [1:0]                sel_r;
  logic [2:0]                term_r;
  logic [VW-1:0]             vtx_r [3];
  logic signed [DIFF_W-1:0]  u_r [3];
  logic signed [DIFF_W-1:0]  w_r [3];
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [FACE_W-1:0]  face_r [3];
  logic [ACC_BITS-1:0]       mag_r [3];
  logic [2:0]                neg_r;
  logic [SQ_W-1:0]           sq_r, sum_r, n_r, root_r;
  logic [4:0]                k_r;
  logic [REM_W-1:0]          rem_r, div_r;
  logic [QUO_W-1:0]          quo_r;
  logic [3:0]                qi_r;
  logic signed [NORM_W-1:0]  nrm_r [3];
  logic                      zero_r;
  logic                      out_valid_r;
  res_t                      res_r, res_nxt;

  logic                 v_we, a_we;
  logic [AW-1:0]        v_waddr, v_raddr, a_waddr, a_raddr;
  logic [VW-1:0]        v_wdata, v_rdata;
  logic [AccW-1:0]      a_wdata, a_rdata, a_sum;
  logic [CORNER_W-1:0]  tgt_idx;
  logic signed [DIFF_W-1:0] mul_a, mul_b;
  logic                 out_free;
  logic                 big, all_zero;
  logic [SQ_W-1:0]      bitv, trial;
  logic [LEN_W-1:0]     len;
  logic                 ge;
  logic [QUO_W-1:0]     q_step;
  logic [NORM_W-1:0]    q_ext;

  ftvn_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vtx_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  ftvn_ram #(.WIDTH(AccW), .DEPTH(MAX_VERTICES)) u_acc_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign clearing  = (st_r == ST_CLEAR);
  assign len       = root_r[LEN_W-1:0];
  assign bitv      = SQ_W'(1) << {k_r, 1'b0};
  assign trial     = root_r + bitv;
  assign ge        = (rem_r >= div_r);
  assign q_step    = {quo_r[QUO_W-2:0], ge};
  assign q_ext     = NORM_W'(q_step);

  always_comb begin
    unique case (sel_r)
      2'd0:    tgt_idx = cmd_r.a;
      2'd1:    tgt_idx = cmd_r.b;
      default: tgt_idx = cmd_r.c;
    endcase
  end

  always_comb begin
    unique case (term_r)
      3'd0:    begin mul_a = u_r[1]; mul_b = w_r[2]; end
      3'd1:    begin mul_a = u_r[2]; mul_b = w_r[1]; end
      3'd2:    begin mul_a = u_r[2]; mul_b = w_r[0]; end
      3'd3:    begin mul_a = u_r[0]; mul_b = w_r[2]; end
      3'd4:    begin mul_a = u_r[0]; mul_b = w_r[1]; end
      3'd5:    begin mul_a = u_r[1]; mul_b = w_r[0]; end
      default: begin mul_a = u_r[0]; mul_b = w_r[0]; end
    endcase
  end

  always_comb begin
    logic signed [ACC_BITS-1:0] acc;
    logic signed [AccP1-1:0]    s;
    big      = 1'b0;
    all_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      acc = $signed(a_rdata[i*ACC_BITS +: ACC_BITS]);
      s   = AccP1'(acc) + AccP1'(face_r[i]);
      if (s[ACC_BITS] != s[ACC_BITS-1]) begin
        a_sum[i*ACC_BITS +: ACC_BITS] = s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                                    : {1'b0, {(ACC_BITS-1){1'b1}}};
      end else begin
        a_sum[i*ACC_BITS +: ACC_BITS] = s[ACC_BITS-1:0];
      end
      big      = big || (|mag_r[i][ACC_BITS-1:MAG_W]);
      all_zero = all_zero && (mag_r[i] == '0);
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: if (clr_r == LAST_ADDR) st_nxt = ST_IDLE;
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_LOAD:  st_nxt = ST_LOAD;
            OP_FACE:  st_nxt = ST_VRD;
            OP_ADD:   st_nxt = ST_ARD;
            OP_READ:  st_nxt = ST_NRD;
            default:  st_nxt = ST_EMIT;
          endcase
        end
      end
      ST_LOAD:  st_nxt = ST_IDLE;
      ST_VRD:   st_nxt = ST_VCAP;
      ST_VCAP:  st_nxt = (sel_r == 2'd2) ? ST_DIFF : ST_VRD;
      ST_DIFF:  st_nxt = ST_MUL;
      ST_MUL:   st_nxt = ST_MACC;
      ST_MACC:  st_nxt = (term_r == 3'd5) ? ST_ARD : ST_MUL;
      ST_ARD:   st_nxt = ST_AWR;
      ST_AWR:   st_nxt = (sel_r == 2'd2) ? ST_EMIT : ST_ARD;
      ST_NRD:   st_nxt = ST_NCAP;
      ST_NCAP:  st_nxt = ST_NSH;
      ST_NSH: begin
        priority if (big)      st_nxt = ST_NSH;
        else if (all_zero)     st_nxt = ST_EMIT;
        else                   st_nxt = ST_NSQ;
      end
      ST_NSQ:   st_nxt = ST_NSUM;
      ST_NSUM:  st_nxt = (sel_r == 2'd2) ? ST_SQRT : ST_NSQ;
      ST_SQRT:  st_nxt = (k_r == '0) ? ST_DINIT : ST_SQRT;
      ST_DINIT: st_nxt = ST_DIV;
      ST_DIV: begin
        if (qi_r == '0) st_nxt = (sel_r == 2'd2) ? ST_EMIT : ST_DINIT;
      end
      ST_EMIT:  if (out_free) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // memory controls, command pop and result word
  always_comb begin
    cmd_ready = (st_r == ST_IDLE);
    v_we      = (st_r == ST_LOAD);
    v_waddr   = AW'(cmd_r.a);
    v_wdata   = {cmd_r.pz, cmd_r.py, cmd_r.px};
    v_raddr   = AW'(tgt_idx);
    a_raddr   = (st_r == ST_NRD) ? AW'(cmd_r.a) : AW'(tgt_idx);
    a_we      = 1'b0;
    a_waddr   = AW'(tgt_idx);
    a_wdata   = a_sum;
    unique case (st_r)
      ST_CLEAR: begin
        a_we    = 1'b1;
        a_waddr = clr_r;
        a_wdata = '0;
      end
      ST_LOAD: begin
        a_we    = 1'b1;
        a_waddr = AW'(cmd_r.a);
        a_wdata = '0;
      end
      ST_AWR:  a_we = 1'b1;
      default: a_we = 1'b0;
    endcase

    res_nxt = '0;
    unique case (cmd_r.op)
      OP_FACE, OP_ADD: begin
        res_nxt.tri_valid = 1'b1;
        res_nxt.tri_first = cmd_r.a[VIDX_W-1:0];
        res_nxt.tri_prev  = cmd_r.b[VIDX_W-1:0];
        res_nxt.tri_cur   = cmd_r.c[VIDX_W-1:0];
      end
      OP_ERR: res_nxt.index_error = 1'b1;
      OP_BADREAD: begin
        res_nxt.norm_valid  = 1'b1;
        res_nxt.index_error = 1'b1;
      end
      OP_READ: begin
        res_nxt.norm_valid  = 1'b1;
        res_nxt.zero_normal = zero_r;
        res_nxt.norm_x      = zero_r ? '0 : nrm_r[0];
        res_nxt.norm_y      = zero_r ? '0 : nrm_r[1];
        res_nxt.norm_z      = zero_r ? '0 : nrm_r[2];
      end
      default: res_nxt = '0;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: if (cmd_valid) cmd_r <= cmd;
      ST_VCAP: vtx_r[sel_r] <= v_rdata;
      ST_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          u_r[i] <= DIFF_W'($signed(vtx_r[2][i*POS_W +: POS_W])) -
                    DIFF_W'($signed(vtx_r[1][i*POS_W +: POS_W]));
          w_r[i] <= DIFF_W'($signed(vtx_r[0][i*POS_W +: POS_W])) -
                    DIFF_W'($signed(vtx_r[1][i*POS_W +: POS_W]));
        end
      end
      ST_MUL: prod_r <= mul_a * mul_b;
      ST_MACC: begin
        if (!term_r[0]) face_r[term_r[2:1]] <= FACE_W'(prod_r);
        else face_r[term_r[2:1]] <= face_r[term_r[2:1]] - FACE_W'(prod_r);
      end
      ST_NCAP: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= a_rdata[i*ACC_BITS + ACC_BITS - 1];
          mag_r[i] <= a_rdata[i*ACC_BITS + ACC_BITS - 1]
                      ? -a_rdata[i*ACC_BITS +: ACC_BITS]
                      : a_rdata[i*ACC_BITS +: ACC_BITS];
        end
      end
      ST_NSH: begin
        if (big) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
        end else begin
          zero_r <= all_zero;
          sum_r  <= '0;
        end
      end
      ST_NSQ: sq_r <= SQ_W'(mag_r[sel_r][MAG_W-1:0] * mag_r[sel_r][MAG_W-1:0]);
      ST_NSUM: begin
        sum_r  <= sum_r + sq_r;
        n_r    <= sum_r + sq_r;
        root_r <= '0;
        k_r    <= '1;
      end
      ST_SQRT: begin
        if (n_r >= trial) begin
          n_r    <= n_r - trial;
          root_r <= (root_r >> 1) + bitv;
        end else begin
          root_r <= root_r >> 1;
        end
        k_r <= k_r - 5'd1;
      end
      ST_DINIT: begin
        rem_r <= REM_W'({mag_r[sel_r][MAG_W-1:0], FRAC_BITS'(0)}) + REM_W'(len >> 1);
        div_r <= REM_W'({len, FRAC_BITS'(0)});
        quo_r <= '0;
        qi_r  <= 4'(QUO_W - 1);
      end
      ST_DIV: begin
        if (ge) rem_r <= rem_r - div_r;
        div_r <= div_r >> 1;
        quo_r <= q_step;
        qi_r  <= qi_r - 4'd1;
        if (qi_r == '0) nrm_r[sel_r] <= neg_r[sel_r] ? -q_ext : q_ext;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_r       <= '0;
      sel_r       <= '0;
      term_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        ST_CLEAR: clr_r <= clr_r + AW'(1);
        ST_IDLE:  if (cmd_valid) sel_r <= (cmd.op == OP_ADD) ? 2'd2 : 2'd0;
        ST_VCAP:  sel_r <= (sel_r == 2'd2) ? 2'd0 : sel_r + 2'd1;
        ST_DIFF:  term_r <= '0;
        ST_MACC:  term_r <= term_r + 3'd1;
        ST_AWR:   sel_r <= sel_r + 2'd1;
        ST_NSH:   sel_r <= '0;
        ST_NSUM:  sel_r <= (sel_r == 2'd2) ? 2'd0 : sel_r + 2'd1;
        ST_DIV:   if (qi_r == '0) sel_r <= sel_r + 2'd1;
        default: ;
      endcase
      if (st_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
        res_r       <= res_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.tri_valid && res_r.norm_valid))
    else $error("result carries both a triangle and a normal");

  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.zero_normal |->
      res_r.norm_x == 0 && res_r.norm_y == 0 && res_r.norm_z == 0 && !res_r.index_error)
    else $error("zero normal with nonzero components");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.norm_valid |->
      res_r.norm_x >= -16384 && res_r.norm_x <= 16384 &&
      res_r.norm_y >= -16384 && res_r.norm_y <= 16384 &&
      res_r.norm_z >= -16384 && res_r.norm_z <= 16384)
    else $error("normal component out of unit range");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DIV |-> rem_r < (div_r << 1))
    else $error("division remainder out of bound");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_CLEAR |-> !cmd_ready && !out_valid_r)
    else $error("activity during accumulator clear");

endmodule

`default_nettype wire
